[src/polynomial_newton_root_defines.svh]
// ----------------------------------------------------------------------------
// polynomial_newton_root assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef POLYNOMIAL_NEWTON_ROOT_DEFINES_SVH
`define POLYNOMIAL_NEWTON_ROOT_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define PNR_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define PNR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/pnr_pkg.sv]
// ----------------------------------------------------------------------------
// pnr_pkg
// shared types, codes and fixed-point helpers of the newton root finder
// ----------------------------------------------------------------------------
`default_nettype none

package pnr_pkg;

  localparam int MAX_DEGREE  = 15;
  localparam int STORE_DEPTH = MAX_DEGREE + 1;
  localparam int COEF_AW     = $clog2(STORE_DEPTH);

  localparam int DATA_W     = 64;
  localparam int DEGREE_W   = 4;
  localparam int ITER_W     = 22;
  localparam int THR_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [DATA_W-1:0] FX_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] FX_MIN = 64'h8000_0000_0000_0000;

  // input operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_SOLVE = 1'b1;

  // stop reasons
  localparam logic [1:0] REASON_SMALL_DERIV = 2'd0;
  localparam logic [1:0] REASON_REPEAT      = 2'd1;
  localparam logic [1:0] REASON_LIMIT       = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_THR = 2'd2;

  localparam logic [DEGREE_W-1:0] DEGREE_RST = 4'd4;
  localparam logic [ITER_W-1:0]   ITER_RST   = 22'd4000000;
  localparam logic [THR_W-1:0]    THR_RST    = 32'd4295;

  typedef struct packed {
    logic                     op;
    logic [3:0]               coef_index;
    logic signed [DATA_W-1:0] coef_value;
    logic signed [DATA_W-1:0] start_x;
  } pnr_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] root;
    logic [1:0]               stop_reason;
    logic [ITER_W-1:0]        steps_taken;
    logic                     saturated;
  } pnr_out_t;

  typedef enum logic [1:0] {
    MUL_COEF,
    MUL_PD,
    MUL_P
  } mul_sel_t;

  typedef enum logic [1:0] {
    ADD_NONE,
    ADD_P,
    ADD_PD
  } add_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PASS,
    ST_LEAD,
    ST_LEAD_WAIT,
    ST_LOOP,
    ST_PD_WAIT,
    ST_P_WAIT,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_DONE
  } pnr_state_t;

  typedef struct packed {
    logic               load_we;
    logic               init;
    logic               rd_en;
    logic [COEF_AW-1:0] rd_addr;
    logic               pd_load;
    logic               mul_start;
    mul_sel_t           mul_sel;
    add_op_t            add_op;
    logic               save_prev;
    logic               div_start;
    logic               x_update;
  } pnr_cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic small_deriv;
    logic x_repeat;
  } pnr_sts_t;

  typedef struct packed {
    logic              ovf;
    logic [DATA_W-1:0] val;
  } sat_res_t;

  function automatic logic [DATA_W-1:0] magn(logic [DATA_W-1:0] a);
    return a[DATA_W-1] ? (~a + 64'd1) : a;
  endfunction

  // apply sign to a magnitude, clamping to the int64 range
  function automatic sat_res_t sat_signed(logic [DATA_W-1:0] m, logic neg, logic over);
    sat_res_t          r;
    logic [DATA_W-1:0] limit;
    limit = neg ? FX_MIN : FX_MAX;
    if (over || (m > limit)) begin
      r.ovf = 1'b1;
      r.val = neg ? FX_MIN : FX_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = neg ? (~m + 64'd1) : m;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[src/pnr_mul.sv]
// ----------------------------------------------------------------------------
// pnr_mul
// Q32.32 multiplier, one 32x32 partial product per cycle, rounded and clamped
// ----------------------------------------------------------------------------
`default_nettype none

module pnr_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pnr_pkg::DATA_W-1:0]    a,
  input  wire logic [pnr_pkg::DATA_W-1:0]    b,
  output logic                               done,
  output logic [pnr_pkg::DATA_W-1:0]         res,
  output logic                               ovf
);

  localparam logic [2:0] PH_ROUND = 3'd5;
  localparam logic [2:0] PH_CLAMP = 3'd6;
  localparam logic [2:0] PH_LAST_PP = 3'd3;

  logic         active_r;
  logic [2:0]   ph_r;
  logic         done_r;
  logic         pp_v_r;
  logic         neg_r;
  logic [63:0]  ma_r;
  logic [63:0]  mb_r;
  logic [63:0]  pp_r;
  logic [1:0]   pp_sh_r;
  logic [127:0] acc_r;
  logic [63:0]  res_r;
  logic         ovf_r;

  logic [31:0]  a_half;
  logic [31:0]  b_half;
  logic [63:0]  pp_prod;
  logic [127:0] pp_wide;
  pnr_pkg::sat_res_t sat;

  // ph 0: a0*b0, 1: a0*b1, 2: a1*b0, 3: a1*b1
  assign a_half  = ph_r[1] ? ma_r[63:32] : ma_r[31:0];
  assign b_half  = ph_r[0] ? mb_r[63:32] : mb_r[31:0];
  assign pp_prod = a_half * b_half;

  always_comb begin
    case (pp_sh_r)
      2'd0:    pp_wide = {64'd0, pp_r};
      2'd1:    pp_wide = {32'd0, pp_r, 32'd0};
      2'd2:    pp_wide = {pp_r, 64'd0};
      default: pp_wide = '0;
    endcase
  end

  assign sat = pnr_pkg::sat_signed(acc_r[95:32], neg_r, |acc_r[127:96]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      ph_r     <= '0;
      done_r   <= 1'b0;
      pp_v_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      pp_v_r <= active_r && (ph_r <= PH_LAST_PP);
      if (start) begin
        active_r <= 1'b1;
        ph_r     <= '0;
      end else if (active_r) begin
        if (ph_r == PH_CLAMP) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
        ph_r <= ph_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    pp_r    <= pp_prod;
    pp_sh_r <= {1'b0, ph_r[1]} + {1'b0, ph_r[0]};
    if (start) begin
      neg_r <= a[63] ^ b[63];
      ma_r  <= pnr_pkg::magn(a);
      mb_r  <= pnr_pkg::magn(b);
      acc_r <= '0;
    end else if (pp_v_r) begin
      acc_r <= acc_r + pp_wide;
    end else if (active_r && (ph_r == PH_ROUND)) begin
      // round half away from zero on the magnitude
      acc_r <= acc_r + 128'h8000_0000;
    end
    if (active_r && (ph_r == PH_CLAMP)) begin
      res_r <= sat.val;
      ovf_r <= sat.ovf;
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign ovf  = ovf_r;

endmodule

`default_nettype wire

[src/pnr_div.sv]
// ----------------------------------------------------------------------------
// pnr_div
// Q32.32 divider, restoring, one quotient bit per cycle, rounded and clamped
// ----------------------------------------------------------------------------
`default_nettype none

module pnr_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [pnr_pkg::DATA_W-1:0]    n,
  input  wire logic [pnr_pkg::DATA_W-1:0]    d,
  output logic                               done,
  output logic [pnr_pkg::DATA_W-1:0]         res,
  output logic                               ovf
);

  localparam logic [6:0] DIV_BITS  = 7'd96;
  localparam logic [6:0] CNT_ROUND = 7'd96;
  localparam logic [6:0] CNT_CLAMP = 7'd97;

  logic        active_r;
  logic [6:0]  cnt_r;
  logic        done_r;
  logic        neg_r;
  logic [95:0] num_r;
  logic [63:0] md_r;
  logic [63:0] rem_r;
  logic [63:0] q_r;
  logic        over_r;
  logic [63:0] res_r;
  logic        ovf_r;

  logic [63:0] rs;
  logic        ge;
  pnr_pkg::sat_res_t sat;

  // remainder stays below the divisor, so its top bit is always clear
  assign rs  = {rem_r[62:0], num_r[95]};
  assign ge  = rs >= md_r;
  assign sat = pnr_pkg::sat_signed(q_r, neg_r, over_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      cnt_r    <= '0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= '0;
      end else if (active_r) begin
        if (cnt_r == CNT_CLAMP) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
        cnt_r <= cnt_r + 7'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r  <= n[63] ^ d[63];
      num_r  <= {pnr_pkg::magn(n), 32'd0};
      md_r   <= pnr_pkg::magn(d);
      rem_r  <= '0;
      q_r    <= '0;
      over_r <= 1'b0;
    end else if (active_r) begin
      if (cnt_r < DIV_BITS) begin
        if (q_r[63]) begin
          over_r <= 1'b1;
        end
        q_r   <= {q_r[62:0], ge};
        rem_r <= ge ? (rs - md_r) : rs;
        num_r <= {num_r[94:0], 1'b0};
      end else if (cnt_r == CNT_ROUND) begin
        if (rem_r >= (md_r - rem_r)) begin
          q_r <= q_r + 64'd1;
          if (&q_r) begin
            over_r <= 1'b1;
          end
        end
      end else if (cnt_r == CNT_CLAMP) begin
        res_r <= sat.val;
        ovf_r <= sat.ovf;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;
  assign ovf  = ovf_r;

endmodule

`default_nettype wire

[src/pnr_datapath.sv]
// ----------------------------------------------------------------------------
// pnr_datapath
// coefficient store, x and horner registers, saturating adders, mul and div
// ----------------------------------------------------------------------------
`default_nettype none

module pnr_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire pnr_pkg::pnr_cmd_t             cmd,
  input  wire pnr_pkg::pnr_in_t              in_data,
  input  wire logic [pnr_pkg::THR_W-1:0]     deriv_threshold,
  output pnr_pkg::pnr_sts_t                  sts,
  output logic [pnr_pkg::DATA_W-1:0]         root,
  output logic [pnr_pkg::ITER_W-1:0]         steps_taken,
  output logic                               saturated
);

  logic [63:0] coef_mem [pnr_pkg::STORE_DEPTH];
  logic [63:0] coef_rd_r;

  logic [63:0] x_r;
  logic [63:0] prev_x_r;
  logic        prev_valid_r;
  logic [63:0] p_r;
  logic [63:0] pd_r;
  logic [pnr_pkg::ITER_W-1:0] step_r;
  logic        ovf_r;

  logic [63:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_res;
  logic        mul_ovf;
  logic        div_done;
  logic [63:0] div_res;
  logic        div_ovf;

  logic [63:0] add_a;
  pnr_pkg::sat_res_t add_r;
  pnr_pkg::sat_res_t sub_r;
  logic        add_en;
  logic        ovf_hit;

  function automatic pnr_pkg::sat_res_t fx_add(logic [63:0] a, logic [63:0] b);
    pnr_pkg::sat_res_t r;
    logic [63:0]       s;
    s = a + b;
    if (!(a[63] ^ b[63]) && (a[63] ^ s[63])) begin
      r.ovf = 1'b1;
      r.val = a[63] ? pnr_pkg::FX_MIN : pnr_pkg::FX_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = s;
    end
    return r;
  endfunction

  function automatic pnr_pkg::sat_res_t fx_sub(logic [63:0] a, logic [63:0] b);
    pnr_pkg::sat_res_t r;
    logic [63:0]       s;
    s = a - b;
    if ((a[63] ^ b[63]) && (a[63] ^ s[63])) begin
      r.ovf = 1'b1;
      r.val = a[63] ? pnr_pkg::FX_MIN : pnr_pkg::FX_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = s;
    end
    return r;
  endfunction

  // coefficient store
  always_ff @(posedge clk) begin
    if (cmd.load_we) begin
      coef_mem[in_data.coef_index] <= in_data.coef_value;
    end
    if (cmd.rd_en) begin
      coef_rd_r <= coef_mem[cmd.rd_addr];
    end
  end

  always_comb begin
    case (cmd.mul_sel)
      pnr_pkg::MUL_COEF: mul_a = coef_rd_r;
      pnr_pkg::MUL_PD:   mul_a = pd_r;
      pnr_pkg::MUL_P:    mul_a = p_r;
      default:           mul_a = coef_rd_r;
    endcase
  end

  pnr_mul u_pnr_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (x_r),
    .done  (mul_done),
    .res   (mul_res),
    .ovf   (mul_ovf)
  );

  pnr_div u_pnr_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .n     (p_r),
    .d     (pd_r),
    .done  (div_done),
    .res   (div_res),
    .ovf   (div_ovf)
  );

  // horner step: pd takes p + pd*x, p takes coef + p*x
  assign add_a   = (cmd.add_op == pnr_pkg::ADD_PD) ? p_r : coef_rd_r;
  assign add_r   = fx_add(add_a, mul_res);
  assign sub_r   = fx_sub(x_r, div_res);
  assign add_en  = (cmd.add_op == pnr_pkg::ADD_P) || (cmd.add_op == pnr_pkg::ADD_PD);
  assign ovf_hit = (add_en && (add_r.ovf || mul_ovf))
                || (cmd.x_update && (sub_r.ovf || div_ovf));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_valid_r <= 1'b0;
      step_r       <= '0;
      ovf_r        <= 1'b0;
    end else if (cmd.init) begin
      prev_valid_r <= 1'b0;
      step_r       <= '0;
      ovf_r        <= 1'b0;
    end else begin
      if (cmd.save_prev) begin
        prev_valid_r <= 1'b1;
      end
      if (cmd.x_update) begin
        step_r <= step_r + 22'd1;
      end
      if (ovf_hit) begin
        ovf_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      x_r <= in_data.start_x;
    end else if (cmd.x_update) begin
      x_r <= sub_r.val;
    end
    if (cmd.save_prev) begin
      prev_x_r <= x_r;
    end
    if (cmd.pd_load) begin
      pd_r <= coef_rd_r;
    end else if (cmd.add_op == pnr_pkg::ADD_PD) begin
      pd_r <= add_r.val;
    end
    if (cmd.add_op == pnr_pkg::ADD_P) begin
      p_r <= add_r.val;
    end
  end

  always_comb begin
    sts.mul_done    = mul_done;
    sts.div_done    = div_done;
    // a zero derivative stops even when the threshold is zero
    sts.small_deriv = (pd_r == 64'd0)
                   || (pnr_pkg::magn(pd_r) < {32'd0, deriv_threshold});
    sts.x_repeat    = prev_valid_r && (prev_x_r == x_r);
  end

  assign root        = x_r;
  assign steps_taken = step_r;
  assign saturated   = ovf_r;

endmodule

`default_nettype wire

[src/pnr_ctrl.sv]
// ----------------------------------------------------------------------------
// pnr_ctrl
// sequencer for coefficient loads and newton passes
// ----------------------------------------------------------------------------
`default_nettype none

module pnr_ctrl (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  input  wire logic                           op,
  input  wire logic [pnr_pkg::DEGREE_W-1:0]   degree,
  input  wire logic [pnr_pkg::ITER_W-1:0]     max_iterations,
  input  wire pnr_pkg::pnr_sts_t              sts,
  output pnr_pkg::pnr_cmd_t                   cmd,
  output logic                                busy,
  output logic                                out_strobe,
  output logic [1:0]                          stop_reason
);

  pnr_pkg::pnr_state_t state_r, state_nxt;
  logic [pnr_pkg::ITER_W-1:0]  left_r, left_nxt;
  logic [pnr_pkg::COEF_AW-1:0] k_r, k_nxt;
  logic [1:0]                  reason_r, reason_nxt;
  logic [pnr_pkg::COEF_AW-1:0] deg_n;

  // degree zero runs as degree one
  assign deg_n = (degree == '0) ? pnr_pkg::COEF_AW'(1) : degree;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pnr_pkg::ST_IDLE;
      left_r   <= '0;
      k_r      <= '0;
      reason_r <= pnr_pkg::REASON_LIMIT;
    end else begin
      state_r  <= state_nxt;
      left_r   <= left_nxt;
      k_r      <= k_nxt;
      reason_r <= reason_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    left_nxt   = left_r;
    k_nxt      = k_r;
    reason_nxt = reason_r;
    cmd        = '0;
    case (state_r)
      pnr_pkg::ST_IDLE: begin
        if (start) begin
          if (op == pnr_pkg::OP_LOAD) begin
            cmd.load_we = 1'b1;
          end else begin
            cmd.init   = 1'b1;
            left_nxt   = max_iterations;
            reason_nxt = pnr_pkg::REASON_LIMIT;
            state_nxt  = pnr_pkg::ST_PASS;
          end
        end
      end
      pnr_pkg::ST_PASS: begin
        if (left_r == '0) begin
          state_nxt = pnr_pkg::ST_DONE;
        end else begin
          left_nxt    = left_r - 22'd1;
          cmd.rd_en   = 1'b1;
          cmd.rd_addr = deg_n;
          state_nxt   = pnr_pkg::ST_LEAD;
        end
      end
      pnr_pkg::ST_LEAD: begin
        // top coefficient seeds pd and the first product
        cmd.pd_load   = 1'b1;
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = pnr_pkg::MUL_COEF;
        cmd.rd_en     = 1'b1;
        cmd.rd_addr   = deg_n - pnr_pkg::COEF_AW'(1);
        state_nxt     = pnr_pkg::ST_LEAD_WAIT;
      end
      pnr_pkg::ST_LEAD_WAIT: begin
        if (sts.mul_done) begin
          cmd.add_op = pnr_pkg::ADD_P;
          k_nxt      = deg_n - pnr_pkg::COEF_AW'(1);
          state_nxt  = pnr_pkg::ST_LOOP;
        end
      end
      pnr_pkg::ST_LOOP: begin
        if (k_r == '0) begin
          state_nxt = pnr_pkg::ST_CHECK;
        end else begin
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = pnr_pkg::MUL_PD;
          cmd.rd_en     = 1'b1;
          cmd.rd_addr   = k_r - pnr_pkg::COEF_AW'(1);
          state_nxt     = pnr_pkg::ST_PD_WAIT;
        end
      end
      pnr_pkg::ST_PD_WAIT: begin
        // p product starts on the old p while pd is written
        if (sts.mul_done) begin
          cmd.add_op    = pnr_pkg::ADD_PD;
          cmd.mul_start = 1'b1;
          cmd.mul_sel   = pnr_pkg::MUL_P;
          state_nxt     = pnr_pkg::ST_P_WAIT;
        end
      end
      pnr_pkg::ST_P_WAIT: begin
        if (sts.mul_done) begin
          cmd.add_op = pnr_pkg::ADD_P;
          k_nxt      = k_r - pnr_pkg::COEF_AW'(1);
          state_nxt  = pnr_pkg::ST_LOOP;
        end
      end
      pnr_pkg::ST_CHECK: begin
        if (sts.small_deriv) begin
          reason_nxt = pnr_pkg::REASON_SMALL_DERIV;
          state_nxt  = pnr_pkg::ST_DONE;
        end else if (sts.x_repeat) begin
          reason_nxt = pnr_pkg::REASON_REPEAT;
          state_nxt  = pnr_pkg::ST_DONE;
        end else begin
          cmd.save_prev = 1'b1;
          cmd.div_start = 1'b1;
          state_nxt     = pnr_pkg::ST_DIV_WAIT;
        end
      end
      pnr_pkg::ST_DIV_WAIT: begin
        if (sts.div_done) begin
          cmd.x_update = 1'b1;
          state_nxt    = pnr_pkg::ST_PASS;
        end
      end
      pnr_pkg::ST_DONE: begin
        state_nxt = pnr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pnr_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy        = (state_r != pnr_pkg::ST_IDLE);
  assign out_strobe  = (state_r == pnr_pkg::ST_DONE);
  assign stop_reason = reason_r;

endmodule

`default_nettype wire

[src/polynomial_newton_root.sv]
// ----------------------------------------------------------------------------
// polynomial_newton_root
// newton-raphson root finder for a Q32.32 polynomial of degree up to 15
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. A load beat writes one
// coefficient and gives no result. A solve beat runs Newton passes from
// start_x; each pass uses the multiplier twice per Horner term and then the
// bit-serial divider, and a pass that ends the solve early skips the divider.
// The result appears on out_data for exactly one cycle with out_strobe high,
// and cannot be held off by the receiver; busy drops in the following cycle.
// Configuration writes belong to idle periods.
`default_nettype none

module polynomial_newton_root (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire pnr_pkg::pnr_in_t                  in_data,
  output logic                                   out_strobe,
  output pnr_pkg::pnr_out_t                      out_data,
  input  wire logic                              cfg_we,
  input  wire logic [pnr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [pnr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic [pnr_pkg::DEGREE_W-1:0] degree_r;
  logic [pnr_pkg::ITER_W-1:0]   max_iter_r;
  logic [pnr_pkg::THR_W-1:0]    deriv_thr_r;

  pnr_pkg::pnr_cmd_t cmd;
  pnr_pkg::pnr_sts_t sts;

  logic [pnr_pkg::DATA_W-1:0] root;
  logic [pnr_pkg::ITER_W-1:0] steps_taken;
  logic                       saturated;
  logic [1:0]                 stop_reason;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r    <= pnr_pkg::DEGREE_RST;
      max_iter_r  <= pnr_pkg::ITER_RST;
      deriv_thr_r <= pnr_pkg::THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        pnr_pkg::CFG_DEGREE:    degree_r    <= cfg_wdata[pnr_pkg::DEGREE_W-1:0];
        pnr_pkg::CFG_MAX_ITER:  max_iter_r  <= cfg_wdata[pnr_pkg::ITER_W-1:0];
        pnr_pkg::CFG_DERIV_THR: deriv_thr_r <= cfg_wdata[pnr_pkg::THR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  pnr_ctrl u_pnr_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .op             (in_data.op),
    .degree         (degree_r),
    .max_iterations (max_iter_r),
    .sts            (sts),
    .cmd            (cmd),
    .busy           (busy),
    .out_strobe     (out_strobe),
    .stop_reason    (stop_reason)
  );

  pnr_datapath u_pnr_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_data         (in_data),
    .deriv_threshold (deriv_thr_r),
    .sts             (sts),
    .root            (root),
    .steps_taken     (steps_taken),
    .saturated       (saturated)
  );

  always_comb begin
    out_data.root        = root;
    out_data.stop_reason = stop_reason;
    out_data.steps_taken = steps_taken;
    out_data.saturated   = saturated;
  end

endmodule

`default_nettype wire

[src/pnr_checker.sv]
// ----------------------------------------------------------------------------
// pnr_checker
// port-level checks of the newton root finder, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "polynomial_newton_root_defines.svh"

module pnr_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire pnr_pkg::pnr_in_t  in_data,
  input wire logic              out_strobe,
  input wire pnr_pkg::pnr_out_t out_data
);

  // a result beat is a lone pulse and the block goes idle right after it
  `PNR_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe && !busy, "result beat not single")

  `PNR_ASSERT_SAME(a_strobe_busy, out_strobe, busy, "result beat while idle")

  `PNR_ASSERT_NEXT(a_solve_busy, start && !busy && (in_data.op == pnr_pkg::OP_SOLVE), busy && !out_strobe, "solve beat not taken up")

  // loads finish in their own cycle and never give a result
  `PNR_ASSERT_NEXT(a_load_quiet, start && !busy && (in_data.op == pnr_pkg::OP_LOAD), !busy && !out_strobe, "load beat left block busy")

  `PNR_ASSERT_SAME(a_reason_code, out_strobe, (out_data.stop_reason == pnr_pkg::REASON_SMALL_DERIV) || (out_data.stop_reason == pnr_pkg::REASON_REPEAT) || (out_data.stop_reason == pnr_pkg::REASON_LIMIT), "unknown stop reason")

endmodule

bind polynomial_newton_root pnr_checker u_pnr_checker (.*);

`default_nettype wire
